### rtl/bgc_pkg.sv
package bgc_pkg;

    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int GROUP_ID_W = 5;

    // Request type codes.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_PAIR   = 2'd1;
    localparam logic [1:0] REQ_NONPAR = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] body_a_index;
        logic               body_a_active;
        logic               body_a_dynamic;
        logic [INDEX_W-1:0] body_b_index;
        logic               body_b_active;
        logic               body_b_dynamic;
    } req_t;

    typedef struct packed {
        logic [GROUP_ID_W-1:0] group_id;
        logic                  error_flag;
    } result_t;

endpackage

### rtl/bgc_mask_mem.sv
module bgc_mask_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds between reads so the controller can use it after the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### rtl/bgc_ffz.sv
module bgc_ffz #(
    parameter int NG = 32,
    parameter int GW = 5
) (
    input  logic [NG-1:0] used,
    output logic [GW-1:0] group
);

    // Lowest free group; saturates at the last group, which is never searched.
    always_comb
    begin
        group = GW'(NG - 1);
        for (int i = NG - 2; i >= 0; i--)
        begin
            if (!used[i])
            begin
                group = GW'(i);
            end
        end
    end

endmodule

### rtl/greedy_body_group_coloring.sv
// The result strobe done is registered in ST_CALC, the state entered at the accepting edge.
// A new request is taken only in ST_IDLE, after ST_CALC and, when a pair writes body b, ST_WRB;
// the mask memory has a single write port, and its read is registered.
// The receiver cannot stall, so done is a one-cycle strobe and never waits.
// Reset clears the control state and count_reg; the mask memory is not
// initialized, and a body's mask must be cleared by a request before it is used.
module greedy_body_group_coloring #(
    parameter int MAX_BODIES = 1024,
    parameter int NUM_GROUPS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bgc_pkg::req_t                req,
    output logic                         done,
    output bgc_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bgc_pkg::COUNT_W-1:0]  cfg_data
);

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int EW = (AW > bgc_pkg::INDEX_W) ? AW : bgc_pkg::INDEX_W;
    localparam logic [NUM_GROUPS-1:0] ONE_BIT = {{(NUM_GROUPS-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_WRB  = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [bgc_pkg::COUNT_W-1:0]     count_reg;
    bgc_pkg::req_t                   req_reg;
    logic                            done_reg, done_next;
    bgc_pkg::result_t                result_reg, result_next;
    logic [AW-1:0]                   addr_b_reg;
    logic [NUM_GROUPS-1:0]           mask_b_reg, mask_b_next;

    logic [AW-1:0]                   rd_addr_a, rd_addr_b, addr_a, addr_b;
    logic [EW-1:0]                   ext_a_in, ext_b_in, ext_a, ext_b;
    logic [NUM_GROUPS-1:0]           rd_data_a, rd_data_b;
    logic                            accept;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [NUM_GROUPS-1:0]           mem_wdata;

    logic                            ok_a, ok_b, use_a, use_b;
    logic                            wr_a, wr_b, err;
    logic [NUM_GROUPS-1:0]           used, new_a;
    logic [GW-1:0]                   free_group;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign ext_a_in  = EW'(req.body_a_index);
    assign ext_b_in  = EW'(req.body_b_index);
    assign rd_addr_a = ext_a_in[AW-1:0];
    assign rd_addr_b = ext_b_in[AW-1:0];
    assign ext_a     = EW'(req_reg.body_a_index);
    assign ext_b     = EW'(req_reg.body_b_index);
    assign addr_a    = ext_a[AW-1:0];
    assign addr_b    = ext_b[AW-1:0];

    bgc_mask_mem #(
        .DEPTH (MAX_BODIES),
        .AW    (AW),
        .WIDTH (NUM_GROUPS)
    ) u_mem (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata)
    );

    assign ok_a  = ({1'b0, req_reg.body_a_index} < count_reg)
                   && (32'(req_reg.body_a_index) < 32'(MAX_BODIES));
    assign ok_b  = ({1'b0, req_reg.body_b_index} < count_reg)
                   && (32'(req_reg.body_b_index) < 32'(MAX_BODIES));
    assign use_a = req_reg.body_a_active && req_reg.body_a_dynamic;
    assign use_b = req_reg.body_b_active && req_reg.body_b_dynamic;
    assign used  = (use_a ? rd_data_a : '0) | (use_b ? rd_data_b : '0);

    bgc_ffz #(
        .NG (NUM_GROUPS),
        .GW (GW)
    ) u_ffz (
        .used  (used),
        .group (free_group)
    );

    // Decode the request held from the accepting edge against the masks just read.
    always_comb
    begin
        err         = 1'b0;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        new_a       = '0;
        mask_b_next = rd_data_b | (ONE_BIT << free_group);
        result_next = '0;
        case (req_reg.req_type)
            bgc_pkg::REQ_CLEAR:
            begin
                err   = !ok_a;
                wr_a  = ok_a;
                new_a = '0;
            end
            bgc_pkg::REQ_PAIR:
            begin
                err   = !(use_a || use_b) || (use_a && !ok_a) || (use_b && !ok_b);
                wr_a  = use_a && !err;
                wr_b  = use_b && !err;
                new_a = rd_data_a | (ONE_BIT << free_group);
                result_next.group_id = bgc_pkg::GROUP_ID_W'(free_group);
            end
            bgc_pkg::REQ_NONPAR:
            begin
                err   = req_reg.body_a_active && !ok_a;
                wr_a  = req_reg.body_a_active && ok_a;
                new_a = rd_data_a | (ONE_BIT << (NUM_GROUPS - 1));
                result_next.group_id = bgc_pkg::GROUP_ID_W'(NUM_GROUPS - 1);
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        if (err)
        begin
            result_next.group_id = '0;
        end
        result_next.error_flag = err;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_a;
        mem_wdata = new_a;
        case (state_reg)
            ST_CALC:
            begin
                mem_we = wr_a;
            end
            ST_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_reg;
                mem_wdata = mask_b_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                done_next  = 1'b1;
                state_next = wr_b ? ST_WRB : ST_IDLE;
            end
            ST_WRB:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_CALC)
        begin
            result_reg <= result_next;
            addr_b_reg <= addr_b;
            mask_b_reg <= mask_b_next;
        end
    end

    a_calc_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |=> done_reg)
        else $error("result strobe missing after mask update");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("mask memory written while idle");

    a_wrb_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRB) |-> $past(state_reg == ST_CALC))
        else $error("second body written without a preceding update");

    a_error_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.error_flag) |-> (result_reg.group_id == '0))
        else $error("rejected request carries a nonzero group");

    a_done_only_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("one request produced two results");

endmodule
